// File: design/pm192_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pm192_pkg;

	localparam int WORD_BITS = 192;
	localparam int OFFS_BITS = 96;

	localparam logic [2:0] KIND_ADD   = 3'd0;
	localparam logic [2:0] KIND_SUB   = 3'd1;
	localparam logic [2:0] KIND_DBL   = 3'd2;
	localparam logic [2:0] KIND_MUL   = 3'd3;
	localparam logic [2:0] KIND_INV   = 3'd4;
	localparam logic [2:0] KIND_HALVE = 3'd5;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] a_limb0;
		logic [63:0] a_limb1;
		logic [63:0] a_limb2;
		logic [63:0] b_limb0;
		logic [63:0] b_limb1;
		logic [63:0] b_limb2;
		logic [7:0]  shift_count;
	} req_item_t;

	typedef struct packed {
		logic [63:0] result_limb0;
		logic [63:0] result_limb1;
		logic [63:0] result_limb2;
	} res_item_t;

endpackage

`default_nettype wire

// File: design/pm192_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pm192_req_if;
	import pm192_pkg::*;
	logic      valid;
	logic      ready;
	req_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface pm192_res_if;
	import pm192_pkg::*;
	logic      valid;
	logic      ready;
	res_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// File: design/pm192_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Digit-serial multiplier: the full product, then folds of the upper half
// times the offset back into the lower half until the upper half is zero.
module pm192_mul #(
	parameter int DIGIT_BITS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [191:0] x,
	input  wire logic [191:0] y,
	input  wire logic [95:0]  k,
	output logic              done,
	output logic [191:0]      lo
);
	import pm192_pkg::*;

	localparam int D  = DIGIT_BITS;
	localparam int N  = (WORD_BITS + D - 1) / D;
	localparam int NK = (OFFS_BITS + D - 1) / D;
	localparam int NW = N * D;
	localparam int KW = NK * D;
	localparam int RW = 2 * NW;
	localparam int IW = $clog2(N);
	localparam int KI = $clog2(NK);
	localparam int RI = $clog2(2 * N);

	localparam logic [1:0] M_IDLE  = 2'd0;
	localparam logic [1:0] M_ISSUE = 2'd1;
	localparam logic [1:0] M_DRAIN = 2'd2;
	localparam logic [1:0] M_CHECK = 2'd3;

	logic [1:0]              state_q;
	logic                    fold_q;
	logic [IW-1:0]           i_q;
	logic [IW-1:0]           j_q;
	logic [N-1:0][D-1:0]     x_q;
	logic [N-1:0][D-1:0]     y_q;
	logic [N-1:0][D-1:0]     h_q;
	logic [NK-1:0][D-1:0]    kd_q;
	logic [2*N-1:0][D-1:0]   r_q;
	logic [RW-1:0]           r_flat;
	logic [D-1:0]            carry_q;
	logic                    done_q;
	logic [191:0]            lo_q;

	logic [2*D-1:0]          prod_s1;
	logic [RI-1:0]           idx_s1;
	logic                    last_s1;
	logic                    vld_s1;

	logic [D-1:0]            op_a;
	logic [D-1:0]            op_b;
	logic [IW-1:0]           rows_m1;
	logic                    row_end;
	logic                    issue_end;
	logic [2*D-1:0]          acc_sum;

	assign r_flat    = r_q;
	assign rows_m1   = fold_q ? IW'(NK - 1) : IW'(N - 1);
	assign row_end   = (j_q == IW'(N - 1));
	assign issue_end = row_end && (i_q == rows_m1);
	assign op_a      = fold_q ? kd_q[i_q[KI-1:0]] : x_q[i_q];
	assign op_b      = fold_q ? h_q[j_q] : y_q[j_q];
	assign acc_sum   = prod_s1 + {{D{1'b0}}, r_q[idx_s1]} + {{D{1'b0}}, carry_q};
	assign done      = done_q;
	assign lo        = lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == M_ISSUE);
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_ISSUE;
					end
				end
				M_ISSUE: begin
					if (issue_end) begin
						state_q <= M_DRAIN;
					end
				end
				M_DRAIN: begin
					state_q <= M_CHECK;
				end
				M_CHECK: begin
					if (r_flat[383:192] == '0) begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end else begin
						state_q <= M_ISSUE;
					end
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	// Issue side: one digit product per cycle, registered before accumulation.
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		idx_s1  <= RI'(i_q) + RI'(j_q);
		last_s1 <= row_end;
		if (state_q == M_IDLE) begin
			x_q    <= NW'(x);
			y_q    <= NW'(y);
			kd_q   <= KW'(k);
			fold_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
		end else if (state_q == M_ISSUE) begin
			if (row_end) begin
				j_q <= '0;
				i_q <= issue_end ? '0 : i_q + 1'b1;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end else if (state_q == M_CHECK) begin
			h_q    <= NW'(r_flat[383:192]);
			fold_q <= 1'b1;
		end
	end

	// Accumulate side: the digit store holds the running sum.
	always_ff @(posedge clk) begin
		if (state_q == M_IDLE) begin
			r_q     <= '0;
			carry_q <= '0;
		end else if (state_q == M_CHECK) begin
			r_q     <= RW'(r_flat[191:0]);
			lo_q    <= r_flat[191:0];
			carry_q <= '0;
		end else if (vld_s1) begin
			r_q[idx_s1] <= acc_sum[D-1:0];
			if (last_s1) begin
				r_q[RI'(idx_s1 + 1'b1)] <= acc_sum[2*D-1:D];
				carry_q <= '0;
			end else begin
				carry_q <= acc_sum[2*D-1:D];
			end
		end
	end

endmodule

`default_nettype wire

// File: design/pm192_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Operation sequencer around one shared 194-bit add/subtract unit.
module pm192_core #(
	parameter int DIGIT_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire pm192_pkg::req_item_t item,
	input  wire logic [95:0]          k,
	output logic                      idle,
	output logic                      fin,
	input  wire logic                 take,
	output logic [191:0]              res
);
	import pm192_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ADD   = 4'd1;
	localparam logic [3:0] S_FINK  = 4'd2;
	localparam logic [3:0] S_SUB1  = 4'd3;
	localparam logic [3:0] S_SUB2  = 4'd4;
	localparam logic [3:0] S_HALVE = 4'd5;
	localparam logic [3:0] S_EXP   = 4'd6;
	localparam logic [3:0] S_MUL   = 4'd7;
	localparam logic [3:0] S_MULW  = 4'd8;
	localparam logic [3:0] S_LOOP  = 4'd9;
	localparam logic [3:0] S_DBL   = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;

	localparam logic [2:0] PH_RA  = 3'd0;
	localparam logic [2:0] PH_RB  = 3'd1;
	localparam logic [2:0] PH_OP  = 3'd2;
	localparam logic [2:0] PH_DBL = 3'd3;
	localparam logic [2:0] PH_SQ  = 3'd4;
	localparam logic [2:0] PH_MA  = 3'd5;

	logic [3:0]   state_q;
	logic [2:0]   phase_q;
	logic [2:0]   kind_q;
	logic [191:0] a_q;
	logic [191:0] b_q;
	logic [191:0] res_q;
	logic [192:0] w_q;
	logic [191:0] e_q;
	logic [7:0]   cnt_q;
	logic [7:0]   bit_q;

	logic [191:0] k192;
	logic [193:0] add_a;
	logic [193:0] add_b;
	logic         add_inv;
	logic [193:0] add_sum;
	logic         no_borrow;
	logic [191:0] fink_res;
	logic         mul_done;
	logic [191:0] mul_lo;
	logic [191:0] mul_x;
	logic [191:0] mul_y;

	assign k192      = {96'd0, k};
	assign add_sum   = add_a + (add_inv ? ~add_b : add_b) + {193'd0, add_inv};
	assign no_borrow = !add_sum[193];
	assign fink_res  = (add_sum[193:192] != 2'b00) ? add_sum[191:0] : w_q[191:0];
	assign idle      = (state_q == S_IDLE);
	assign fin       = (state_q == S_FIN);
	assign res       = res_q;

	assign mul_x = (phase_q == PH_OP) ? a_q : res_q;
	assign mul_y = (phase_q == PH_OP) ? b_q : ((phase_q == PH_SQ) ? res_q : a_q);

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_inv = 1'b0;
		unique case (state_q)
			S_ADD: begin
				case (phase_q)
					PH_RA:   add_a = {2'b00, a_q};
					PH_RB:   add_a = {2'b00, b_q};
					PH_OP: begin
						add_a = {2'b00, a_q};
						add_b = {2'b00, b_q};
					end
					default: begin
						add_a = {2'b00, res_q};
						add_b = {2'b00, res_q};
					end
				endcase
			end
			S_FINK: begin
				add_a = {1'b0, w_q};
				add_b = {2'b00, k192};
			end
			S_SUB1: begin
				add_a   = {2'b00, a_q};
				add_b   = {2'b00, b_q};
				add_inv = 1'b1;
			end
			S_SUB2, S_HALVE: begin
				add_a   = (state_q == S_SUB2) ? {2'b00, w_q[191:0]} : {2'b00, a_q};
				add_b   = {2'b00, k192};
				add_inv = 1'b1;
			end
			S_EXP: begin
				add_a   = {2'b00, ~k192};
				add_b   = 194'd1;
				add_inv = 1'b1;
			end
			default: begin
				add_inv = 1'b0;
			end
		endcase
	end

	pm192_mul #(
		.DIGIT_BITS(DIGIT_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_MUL),
		.x      (mul_x),
		.y      (mul_y),
		.k      (k),
		.done   (mul_done),
		.lo     (mul_lo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_RA;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q <= item.kind;
						a_q    <= {item.a_limb2, item.a_limb1, item.a_limb0};
						b_q    <= {item.b_limb2, item.b_limb1, item.b_limb0};
						cnt_q  <= item.shift_count;
						if (item.kind == KIND_HALVE) begin
							state_q <= S_HALVE;
						end else if (item.kind > KIND_HALVE) begin
							res_q   <= '0;
							state_q <= S_FIN;
						end else begin
							phase_q <= PH_RA;
							state_q <= S_ADD;
						end
					end
				end
				S_ADD: begin
					w_q     <= add_sum[192:0];
					state_q <= S_FINK;
				end
				S_FINK: begin
					case (phase_q)
						PH_RA: begin
							a_q     <= fink_res;
							phase_q <= PH_RB;
							state_q <= S_ADD;
						end
						PH_RB: begin
							b_q <= fink_res;
							case (kind_q)
								KIND_ADD: begin
									phase_q <= PH_OP;
									state_q <= S_ADD;
								end
								KIND_SUB: state_q <= S_SUB1;
								KIND_DBL: begin
									res_q   <= a_q;
									phase_q <= PH_DBL;
									state_q <= S_DBL;
								end
								KIND_MUL: begin
									phase_q <= PH_OP;
									state_q <= S_MUL;
								end
								default:  state_q <= S_EXP;
							endcase
						end
						PH_DBL: begin
							res_q   <= fink_res;
							cnt_q   <= cnt_q - 1'b1;
							state_q <= S_DBL;
						end
						PH_SQ: begin
							res_q <= fink_res;
							if (e_q[191]) begin
								phase_q <= PH_MA;
								state_q <= S_MUL;
							end else begin
								state_q <= S_LOOP;
							end
						end
						PH_MA: begin
							res_q   <= fink_res;
							state_q <= S_LOOP;
						end
						default: begin
							res_q   <= fink_res;
							state_q <= S_FIN;
						end
					endcase
				end
				S_SUB1: begin
					w_q     <= {no_borrow, add_sum[191:0]};
					state_q <= S_SUB2;
				end
				S_SUB2: begin
					res_q   <= w_q[192] ? w_q[191:0] : add_sum[191:0];
					state_q <= S_FIN;
				end
				S_HALVE: begin
					res_q   <= {no_borrow, add_sum[191:1]};
					state_q <= S_FIN;
				end
				S_EXP: begin
					e_q     <= add_sum[191:0];
					res_q   <= 192'd1;
					bit_q   <= 8'd191;
					phase_q <= PH_SQ;
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_MULW;
				end
				S_MULW: begin
					if (mul_done) begin
						w_q     <= {1'b0, mul_lo};
						state_q <= S_FINK;
					end
				end
				S_LOOP: begin
					e_q <= {e_q[190:0], 1'b0};
					if (bit_q == 8'd0) begin
						state_q <= S_FIN;
					end else begin
						bit_q   <= bit_q - 1'b1;
						phase_q <= PH_SQ;
						state_q <= S_MUL;
					end
				end
				S_DBL: begin
					state_q <= (cnt_q == 8'd0) ? S_FIN : S_ADD;
				end
				S_FIN: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/pseudo_mersenne_mod192_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake    Contents
// req      in         valid/ready  kind, operands a and b, shift count
// res      out        valid/ready  192-bit result in three limbs
// apb      in/out     psel/penable modulus offset k, low and high words
//
// One request is worked on at a time. Every kind up to inverse first reduces both
// operands; add-then-halve does not. A multiply forms the full product and then
// folds it in passes (usually two or three); an inverse takes 192 squarings plus
// one multiply per set exponent bit.
// Reset sets k to 2^64 + 1. A full output register holds the core, and with it
// the request side, until the result is taken; otherwise the next request enters.
module pseudo_mersenne_mod192_alu #(
	parameter int DIGIT_BITS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	pm192_req_if.sink         req,
	pm192_res_if.source       res,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);
	import pm192_pkg::*;

	logic [63:0]  k_low_q;
	logic [31:0]  k_high_q;
	logic         core_idle;
	logic         core_fin;
	logic         take;
	logic [191:0] core_res;
	logic         out_valid_q;
	res_item_t    out_item_q;

	// Registers sit on 8-byte boundaries; bit 3 of the address picks one.
	assign pready = 1'b1;
	assign prdata = paddr[3] ? {32'd0, k_high_q} : k_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_low_q  <= 64'd1;
			k_high_q <= 32'd1;
		end else if (psel && penable && pwrite) begin
			if (paddr[3]) begin
				k_high_q <= pwdata[31:0];
			end else begin
				k_low_q <= pwdata;
			end
		end
	end

	assign req.ready = core_idle;

	// The output slot can be refilled in the same cycle it is emptied.
	assign take = !out_valid_q || res.ready;

	pm192_core #(
		.DIGIT_BITS(DIGIT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req.valid && core_idle),
		.item   (req.item),
		.k      ({k_high_q, k_low_q}),
		.idle   (core_idle),
		.fin    (core_fin),
		.take   (take),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_fin && take) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_fin && take) begin
			out_item_q.result_limb0 <= core_res[63:0];
			out_item_q.result_limb1 <= core_res[127:64];
			out_item_q.result_limb2 <= core_res[191:128];
		end
	end

	assign res.valid = out_valid_q;
	assign res.item  = out_item_q;

endmodule

`default_nettype wire

// File: verif/pseudo_mersenne_mod192_alu_tb.sv
`timescale 1ns / 1ps

module pseudo_mersenne_mod192_alu_tb;
	import pm192_pkg::*;

	// Register indexes; each register sits at byte address 8*index because the
	// low offset word is 64 bits wide.
	localparam int REG_OFFS_LOW  = 0;
	localparam int REG_OFFS_HIGH = 1;

	// Extra kinds that the block must answer with an all-zero result.
	localparam logic [2:0] KIND_SPARE6 = 3'd6;
	localparam logic [2:0] KIND_SPARE7 = 3'd7;

	// The slowest correct run is dominated by a handful of inverses; the limit
	// allows for them several times over.
	localparam int CYCLE_LIMIT = 3000000;
	localparam int TAIL_CYCLES = 200;

	typedef bit [191:0] word_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	pm192_req_if req_ch();
	pm192_res_if res_ch();

	pseudo_mersenne_mod192_alu dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Our own copy of the modulus offset k, updated as each register write lands.
	bit [63:0] offs_low;
	bit [31:0] offs_high;

	req_item_t request_backlog[$];
	res_item_t awaited_results[$];

	int err_count;
	int send_idle_pct;
	int recv_stall_pct;
	int inv_budget;
	int cycle_count;
	int hold_left;
	bit hold_request;
	bit hold_started;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic bit [95:0] offset_k();
		return {offs_high, offs_low};
	endfunction

	// (x + y) mod m for x, y below 2^192, one conditional correction. When the
	// sum, or the sum plus k, passes 2^192 the corrected value is taken.
	function automatic word_t mod_add(word_t x, word_t y);
		bit [193:0] sum;
		bit [193:0] corr;
		sum  = {2'b00, x} + {2'b00, y};
		corr = sum + {98'd0, offset_k()};
		return (corr[193:192] != 2'b00) ? corr[191:0] : sum[191:0];
	endfunction

	function automatic word_t mod_sub(word_t x, word_t y);
		bit [192:0] diff;
		word_t      r;
		diff = {1'b0, x} - {1'b0, y};
		r = diff[191:0];
		if (diff[192])
			r = r - {96'd0, offset_k()};
		return r;
	endfunction

	// Full product reduced by true division; with k zero the modulus is 2^192.
	function automatic word_t mod_mul(word_t x, word_t y);
		bit [383:0] prod;
		bit [383:0] modulus;
		bit [383:0] rem;
		prod    = {192'd0, x} * {192'd0, y};
		modulus = (384'd1 << 192) - {288'd0, offset_k()};
		rem     = prod % modulus;
		return rem[191:0];
	endfunction

	// a^(m-2) by left-to-right square and multiply over all 192 exponent bits.
	function automatic word_t mod_inverse(word_t a);
		word_t expo;
		word_t acc;
		expo = word_t'(0) - {96'd0, offset_k()} - word_t'(2);
		acc  = word_t'(1);
		for (int bitpos = 191; bitpos >= 0; bitpos--) begin
			acc = mod_mul(acc, acc);
			if (expo[bitpos])
				acc = mod_mul(acc, a);
		end
		return acc;
	endfunction

	// (a + m) >> 1 over 193 bits, with a taken as given.
	function automatic word_t add_modulus_halve(word_t a);
		bit [192:0] sum;
		sum = {1'b0, a} + (193'd1 << 192) - {97'd0, offset_k()};
		return sum[192:1];
	endfunction

	function automatic res_item_t predict_result(req_item_t it);
		word_t     a;
		word_t     b;
		word_t     r;
		res_item_t out;
		a = {it.a_limb2, it.a_limb1, it.a_limb0};
		b = {it.b_limb2, it.b_limb1, it.b_limb0};
		r = '0;
		if (it.kind == KIND_HALVE) begin
			r = add_modulus_halve(a);
		end else if (it.kind <= KIND_INV) begin
			// Operands at or above m are folded back by a single correction.
			a = mod_add(a, '0);
			b = mod_add(b, '0);
			case (it.kind)
				KIND_ADD: r = mod_add(a, b);
				KIND_SUB: r = mod_sub(a, b);
				KIND_DBL: begin
					r = a;
					for (int n = 0; n < it.shift_count; n++)
						r = mod_add(r, r);
				end
				KIND_MUL: r = mod_mul(a, b);
				default:  r = mod_inverse(a);
			endcase
		end
		out.result_limb0 = r[63:0];
		out.result_limb1 = r[127:64];
		out.result_limb2 = r[191:128];
		return out;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $realtime);
		err_count++;
	endtask

	// Request driver. The expectation is formed at the edge where the request is
	// taken, so it always sees the offset that the block is using.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.item  <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				awaited_results.push_back(predict_result(req_ch.item));
			if (!req_ch.valid || req_ch.ready) begin
				if (request_backlog.size() > 0 &&
				    $urandom_range(99) >= send_idle_pct) begin
					req_ch.item  <= request_backlog.pop_front();
					req_ch.valid <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. It also owns the long hold-off, so that the count of
	// stalled cycles is kept apart from the request side.
	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left    <= 0;
			hold_started <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result", res_ch.item.result_limb0, '0);
				end else begin
					want = awaited_results.pop_front();
					if (res_ch.item.result_limb0 !== want.result_limb0)
						report_mismatch("result_limb0", res_ch.item.result_limb0,
							want.result_limb0);
					if (res_ch.item.result_limb1 !== want.result_limb1)
						report_mismatch("result_limb1", res_ch.item.result_limb1,
							want.result_limb1);
					if (res_ch.item.result_limb2 !== want.result_limb2)
						report_mismatch("result_limb2", res_ch.item.result_limb2,
							want.result_limb2);
				end
			end
			if (hold_request && !hold_started) begin
				hold_started <= 1'b1;
				hold_left    <= 400;
				res_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left    <= hold_left - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic word_t rand_word();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	// Operands mix plain random values with values near the modulus, some of
	// them at or just above it, plus the extremes.
	function automatic word_t rand_operand();
		word_t modulus;
		modulus = word_t'(0) - {96'd0, offset_k()};
		case ($urandom_range(4))
			0: return rand_word();
			1: return word_t'($urandom_range(1000));
			2: return modulus - word_t'($urandom_range(3));
			3: return modulus + word_t'($urandom_range(3));
			default: return $urandom_range(1) ? '1 : '0;
		endcase
	endfunction

	function automatic req_item_t make_request(logic [2:0] kind, word_t a, word_t b,
		logic [7:0] count);
		req_item_t it;
		it.kind        = kind;
		it.a_limb0     = a[63:0];
		it.a_limb1     = a[127:64];
		it.a_limb2     = a[191:128];
		it.b_limb0     = b[63:0];
		it.b_limb1     = b[127:64];
		it.b_limb2     = b[191:128];
		it.shift_count = count;
		return it;
	endfunction

	// Inverses are slow, so only a few are allowed
	// into the random part; the spare kinds turn up now and then.
	task automatic queue_random(int count);
		int         pick;
		logic [2:0] kind;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 3 && inv_budget > 0) begin
				kind = KIND_INV;
				inv_budget--;
			end else if (pick < 7) begin
				kind = $urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7;
			end else begin
				case ($urandom_range(4))
					0: kind = KIND_ADD;
					1: kind = KIND_SUB;
					2: kind = KIND_DBL;
					3: kind = KIND_MUL;
					default: kind = KIND_HALVE;
				endcase
			end
			request_backlog.push_back(make_request(kind, rand_operand(), rand_operand(),
				8'($urandom_range(255))));
		end
	endtask

	// Waits until every request has gone in and every result has come back,
	// then waits further so the block is truly idle.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (request_backlog.size() > 0 || req_ch.valid || awaited_results.size() > 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(int index, logic [63:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= 4'(index * 8);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (index == REG_OFFS_LOW)
			offs_low = value;
		else if (index == REG_OFFS_HIGH)
			offs_high = value[31:0];
	endtask

	task automatic set_offset(logic [63:0] low, logic [63:0] high);
		write_reg(REG_OFFS_LOW, low);
		write_reg(REG_OFFS_HIGH, high);
	endtask

	// Directed cases queued in every phase: the halving extremes, which behave quite
	// differently once k is zero.
	task automatic queue_halve_edges();
		request_backlog.push_back(make_request(KIND_HALVE, '0, '0, 8'd0));
		request_backlog.push_back(make_request(KIND_HALVE, '1, '0, 8'd0));
	endtask

	initial begin
		word_t mod_now;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		req_ch.valid   = 1'b0;
		req_ch.item    = '0;
		res_ch.ready   = 1'b0;
		err_count      = 0;
		cycle_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		inv_budget     = 3;
		hold_request   = 1'b0;
		offs_low       = 64'd1;
		offs_high      = 32'd1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Phase one: reset offset, directed cases first, no idling at all.
		mod_now = word_t'(0) - {96'd0, offset_k()};
		request_backlog.push_back(make_request(KIND_ADD, '0, '0, 8'd0));
		request_backlog.push_back(make_request(KIND_ADD, '1, '1, 8'd0));
		request_backlog.push_back(make_request(KIND_ADD, mod_now - 1, word_t'(1), 8'd0));
		request_backlog.push_back(make_request(KIND_SUB, '0, word_t'(1), 8'd0));
		request_backlog.push_back(make_request(KIND_SUB, mod_now - 5, mod_now - 5, 8'd0));
		request_backlog.push_back(make_request(KIND_SUB, '1, mod_now, 8'd0));
		request_backlog.push_back(make_request(KIND_DBL, mod_now + 1, '0, 8'd0));
		request_backlog.push_back(make_request(KIND_DBL, mod_now - 1, '0, 8'd1));
		request_backlog.push_back(make_request(KIND_DBL, '1, '1, 8'd255));
		request_backlog.push_back(make_request(KIND_MUL, '1, '1, 8'd0));
		request_backlog.push_back(make_request(KIND_MUL, '0, rand_word(), 8'd0));
		request_backlog.push_back(make_request(KIND_MUL, mod_now - 1, mod_now - 1, 8'd0));
		request_backlog.push_back(make_request(KIND_INV, mod_now, '0, 8'd0));
		request_backlog.push_back(make_request(KIND_INV, word_t'(2), '0, 8'd0));
		queue_halve_edges();
		request_backlog.push_back(make_request(KIND_SPARE6, '1, '1, 8'hFF));
		request_backlog.push_back(make_request(KIND_SPARE7, '1, '1, 8'hFF));
		queue_random(10);
		wait_idle();

		// Phase two: k zero, so everything wraps modulo 2^192; the sender idles.
		set_offset(64'd0, 64'd0);
		send_idle_pct  = 54;
		recv_stall_pct = 0;
		queue_halve_edges();
		queue_random(15);
		wait_idle();

		// Phase three: the largest k, with junk in the unused upper register bits.
		set_offset('1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_idle_pct  = 0;
		recv_stall_pct = 54;
		queue_halve_edges();
		queue_random(15);
		wait_idle();

		// Phase four: random k, both sides idling lightly.
		set_offset({$urandom, $urandom}, {$urandom, $urandom});
		send_idle_pct  = 12;
		recv_stall_pct = 12;
		queue_halve_edges();
		queue_random(15);
		wait_idle();

		// Phase five: a small k and a long receiver hold-off while requests keep
		// coming, so the output register fills and the request side backs up.
		set_offset(64'd189, 64'd0);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b1;
		queue_halve_edges();
		queue_random(20);
		wait_idle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && awaited_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
